// File: hdl/rbpft_pkg.sv
// Package for the rigid body point force table.
// Holds the body entry layout, op codes, the CORDIC arctangent table and
// the saturation helper. No dependencies.
`default_nettype none
package rbpft_pkg;

  typedef enum logic [2:0] {
    OP_SET_POSE  = 3'd0,
    OP_SET_VEL   = 3'd1,
    OP_SET_FORCE = 3'd2,
    OP_TO_WORLD  = 3'd3,
    OP_POINT_VEL = 3'd4,
    OP_APPLY     = 3'd5,
    OP_READ      = 3'd6
  } op_t;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] angle;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic [31:0] ang_vel;
    logic [31:0] frc_x;
    logic [31:0] frc_y;
    logic [31:0] torque;
  } body_ent_t;

  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam int ATAN_ENTRIES = 30;

  // Arctangent of 2^-i as a binary angle.
  function automatic logic [31:0] atan_turns(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A2F;
      5'd19: r = 32'h00000517;
      5'd20: r = 32'h0000028B;
      5'd21: r = 32'h00000145;
      5'd22: r = 32'h000000A2;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000028;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000002;
      5'd29: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  // Clamp to the signed 32-bit range; bit 32 of the result flags a clamp.
  function automatic logic [32:0] sat32(input logic signed [67:0] v);
    logic [32:0] r;
    if (v > 68'sh0000000007FFFFFFF) begin
      r = {1'b1, 32'h7FFFFFFF};
    end else if (v < 68'shFFFFFFFFF80000000) begin
      r = {1'b1, 32'h80000000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hdl/rbpft_body_mem.sv
// Body table storage: one write port, one registered read port.
// Depends on rbpft_pkg for the entry layout.
`default_nettype none
module rbpft_body_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic                  clk,
  input  wire logic                  wr_en,
  input  wire logic [AW-1:0]         wr_addr,
  input  wire rbpft_pkg::body_ent_t  wr_data,
  input  wire logic                  rd_en,
  input  wire logic [AW-1:0]         rd_addr,
  output rbpft_pkg::body_ent_t       rd_data
);
  import rbpft_pkg::*;

  body_ent_t mem [DEPTH];
  body_ent_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// File: hdl/rbpft_cordic.sv
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// Depends on rbpft_pkg for the gain and arctangent table.
`default_nettype none
module rbpft_cordic #(
  parameter int STEPS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [31:0]        angle,
  output logic                    done,
  output logic signed [32:0]      cos_o,
  output logic signed [32:0]      sin_o
);
  import rbpft_pkg::*;

  localparam int IW = $clog2(STEPS + 1);

  logic signed [33:0] x_r, y_r, z_r;
  logic [IW-1:0]      i_r;
  logic               busy_r, fin_r, neg_r, done_r;
  logic signed [32:0] cos_r, sin_r;
  logic signed [33:0] dx, dy, at;
  logic               pre_neg;
  logic [31:0]        pre_ang;

  assign pre_neg = angle[31] ^ angle[30];
  assign pre_ang = pre_neg ? angle + 32'h80000000 : angle;
  assign dx = y_r >>> i_r;
  assign dy = x_r >>> i_r;
  assign at = $signed({2'b00, atan_turns(5'(i_r))});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        x_r    <= CORDIC_GAIN;
        y_r    <= '0;
        z_r    <= 34'($signed(pre_ang));
        neg_r  <= pre_neg;
        i_r    <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (z_r >= 0) begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - at;
        end else begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + at;
        end
        i_r <= i_r + 1'b1;
        if (i_r == IW'(STEPS - 1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end else if (fin_r) begin
        cos_r  <= neg_r ? 33'(-x_r) : 33'(x_r);
        sin_r  <= neg_r ? 33'(-y_r) : 33'(y_r);
        fin_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign done  = done_r;
  assign cos_o = cos_r;
  assign sin_o = sin_r;

endmodule
`default_nettype wire

// File: hdl/rigid_body_point_force_table_core.sv
// Top level of the rigid body point force table: sequencer, shared multiplier
// and output register. Depends on rbpft_pkg, rbpft_body_mem and rbpft_cordic.
//
//  channel | ports                                   | dir
//  --------+-----------------------------------------+-----
//  input   | in_valid, in_ready, in_op .. in_force_y | in
//  result  | out_valid, out_ready, out_x .. out_sat. | out
//
// One transaction is handled at a time. Set ops and read_force go straight
// from the entry load to the result, and ignored transactions straight to
// the result; to_world, point_velocity and apply_force first run the CORDIC
// iteration and then the single 33x33 multiplier. After reset a clearing
// pass writes zero to all BODIES entries, one per cycle, with in_ready low.
// A waiting result sits in the output register while the next transaction
// is accepted.
`default_nettype none
module rigid_body_point_force_table_core #(
  parameter int BODIES       = 64,
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         in_op,
  input  wire logic [5:0]         in_body,
  input  wire logic signed [31:0] in_x_value,
  input  wire logic signed [31:0] in_y_value,
  input  wire logic signed [31:0] in_w_value,
  input  wire logic signed [31:0] in_force_x,
  input  wire logic signed [31:0] in_force_y,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_x,
  output logic signed [31:0]      out_y,
  output logic signed [31:0]      out_w,
  output logic                    out_saturated
);
  import rbpft_pkg::*;

  localparam int AW = (BODIES > 1) ? $clog2(BODIES) : 1;
  localparam logic signed [66:0] RND30 = 67'sh20000000;
  localparam logic signed [66:0] RND16 = 67'sh8000;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_LOAD, S_CORD, S_R0, S_R1, S_R2, S_R3, S_R4, S_POST,
    S_V1, S_V2, S_V3, S_A1, S_A2, S_A3, S_OUT
  } state_t;

  state_t             state_r;
  logic [AW-1:0]      clr_r, addr_r;
  op_t                op_r;
  logic signed [31:0] lx_r, ly_r, fx_r, fy_r;
  body_ent_t          ent_r;
  logic signed [65:0] prod_r;
  logic signed [66:0] acc_r;
  logic signed [36:0] rx_r, ry_r;
  logic signed [31:0] rxs_r, rys_r, fax_r, fay_r;
  logic [31:0]        res_x_r, res_y_r, res_w_r;
  logic               sat_r;
  logic               out_valid_r;
  logic [31:0]        out_x_r, out_y_r, out_w_r;
  logic               out_sat_r;

  // Memory and CORDIC hookup.
  logic               wr_en, rd_en;
  logic [AW-1:0]      wr_addr, rd_addr;
  body_ent_t          wr_data, rd_data;
  logic               cor_done;
  logic signed [32:0] cos_v, sin_v;

  logic               accept, in_ok;
  logic [AW+5:0]      body_ext;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_nxt;
  logic signed [66:0] sum_v, rnd_v;
  logic [32:0]        wx_s, wy_s, rsx_s, rsy_s, fax_s, fay_s, v_s, tq_s;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign in_ok    = (32'(in_body) < BODIES) && (in_op <= OP_READ);
  assign body_ext = (AW + 6)'(in_body);
  assign rd_en    = accept;
  assign rd_addr  = body_ext[AW-1:0];

  rbpft_body_mem #(.DEPTH(BODIES), .AW(AW)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rbpft_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_LOAD),
    .angle (rd_data.angle),
    .done  (cor_done),
    .cos_o (cos_v),
    .sin_o (sin_v)
  );

  // Shared multiplier: operands picked by the sequencer step, product
  // registered before it is used.
  always_comb begin
    unique case (state_r)
      S_R0:    begin mul_a = cos_v;          mul_b = 33'(lx_r);    end
      S_R1:    begin mul_a = -sin_v;         mul_b = 33'(ly_r);    end
      S_R2:    begin mul_a = sin_v;          mul_b = 33'(lx_r);    end
      S_R3:    begin mul_a = cos_v;          mul_b = 33'(ly_r);    end
      S_V1:    begin mul_a = 33'($signed(ent_r.ang_vel)); mul_b = -33'(rys_r); end
      S_V2:    begin mul_a = 33'($signed(ent_r.ang_vel)); mul_b = 33'(rxs_r);  end
      S_A1:    begin mul_a = 33'(rxs_r);     mul_b = 33'(fy_r);    end
      S_A2:    begin mul_a = 33'(rys_r);     mul_b = -33'(fx_r);   end
      default: begin mul_a = '0;             mul_b = '0;           end
    endcase
  end
  assign prod_nxt = mul_a * mul_b;

  // Rounding sums and saturation.
  assign sum_v = acc_r + 67'(prod_r);
  assign rnd_v = 67'(prod_r) + RND16;
  assign wx_s  = sat32(68'($signed(ent_r.pos_x)) + 68'(rx_r));
  assign wy_s  = sat32(68'($signed(ent_r.pos_y)) + 68'(ry_r));
  assign rsx_s = sat32(68'(rx_r));
  assign rsy_s = sat32(68'(ry_r));
  assign fax_s = sat32(68'($signed(ent_r.frc_x)) + 68'(fx_r));
  assign fay_s = sat32(68'($signed(ent_r.frc_y)) + 68'(fy_r));
  assign v_s   = sat32(68'($signed(state_r == S_V2 ? ent_r.vel_x : ent_r.vel_y))
                       + 68'($signed(rnd_v[66:16])));
  assign tq_s  = sat32(68'($signed(ent_r.torque)) + 68'($signed(sum_v[66:16])));

  // Write port: clearing pass, set ops and the apply_force update.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = addr_r;
    wr_data = ent_r;
    if (state_r == S_CLR) begin
      wr_en   = 1'b1;
      wr_addr = clr_r;
      wr_data = '0;
    end else if (state_r == S_LOAD) begin
      wr_data = rd_data;
      unique case (op_r)
        OP_SET_POSE: begin
          wr_en = 1'b1;
          wr_data.pos_x = lx_r;
          wr_data.pos_y = ly_r;
          wr_data.angle = res_w_r;
        end
        OP_SET_VEL: begin
          wr_en = 1'b1;
          wr_data.vel_x   = lx_r;
          wr_data.vel_y   = ly_r;
          wr_data.ang_vel = res_w_r;
        end
        OP_SET_FORCE: begin
          wr_en = 1'b1;
          wr_data.frc_x  = lx_r;
          wr_data.frc_y  = ly_r;
          wr_data.torque = res_w_r;
        end
        default: wr_en = 1'b0;
      endcase
    end else if (state_r == S_A3) begin
      wr_en = 1'b1;
      wr_data.frc_x  = fax_r;
      wr_data.frc_y  = fay_r;
      wr_data.torque = tq_s[31:0];
    end
  end

  // Sequencer and output register. res_w_r carries w_value until the entry
  // is loaded, since only set ops need it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // In S_OUT the output register is reloaded below, so the drain only
      // applies in the other states.
      if (out_valid_r && out_ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      prod_r <= prod_nxt;
      unique case (state_r)
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == AW'(BODIES - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op_r    <= op_t'(in_op);
            addr_r  <= body_ext[AW-1:0];
            lx_r    <= in_x_value;
            ly_r    <= in_y_value;
            fx_r    <= in_force_x;
            fy_r    <= in_force_y;
            res_x_r <= '0;
            res_y_r <= '0;
            res_w_r <= in_ok ? in_w_value : '0;
            sat_r   <= 1'b0;
            state_r <= in_ok ? S_LOAD : S_OUT;
          end
        end
        S_LOAD: begin
          ent_r   <= rd_data;
          res_w_r <= '0;
          unique case (op_r)
            OP_TO_WORLD, OP_POINT_VEL, OP_APPLY: state_r <= S_CORD;
            OP_READ: begin
              res_x_r <= rd_data.frc_x;
              res_y_r <= rd_data.frc_y;
              res_w_r <= rd_data.torque;
              state_r <= S_OUT;
            end
            default: state_r <= S_OUT;
          endcase
        end
        S_CORD: begin
          if (cor_done) begin
            state_r <= S_R0;
          end
        end
        S_R0: state_r <= S_R1;
        S_R1: begin
          acc_r   <= 67'(prod_r) + RND30;
          state_r <= S_R2;
        end
        S_R2: begin
          rx_r    <= $signed(sum_v[66:30]);
          state_r <= S_R3;
        end
        S_R3: begin
          acc_r   <= 67'(prod_r) + RND30;
          state_r <= S_R4;
        end
        S_R4: begin
          ry_r    <= $signed(sum_v[66:30]);
          state_r <= S_POST;
        end
        S_POST: begin
          // to_world keeps the offset unclamped; point_velocity never forms
          // the world point.
          rxs_r   <= rsx_s[31:0];
          rys_r   <= rsy_s[31:0];
          fax_r   <= fax_s[31:0];
          fay_r   <= fay_s[31:0];
          res_x_r <= wx_s[31:0];
          res_y_r <= wy_s[31:0];
          sat_r   <= sat_r
                   | ((op_r != OP_TO_WORLD) & (rsx_s[32] | rsy_s[32]))
                   | ((op_r != OP_POINT_VEL) & (wx_s[32] | wy_s[32]))
                   | ((op_r == OP_APPLY) & (fax_s[32] | fay_s[32]));
          unique case (op_r)
            OP_POINT_VEL: state_r <= S_V1;
            OP_APPLY:     state_r <= S_A1;
            default:      state_r <= S_OUT;
          endcase
        end
        S_V1: state_r <= S_V2;
        S_V2: begin
          res_x_r <= v_s[31:0];
          sat_r   <= sat_r | v_s[32];
          state_r <= S_V3;
        end
        S_V3: begin
          res_y_r <= v_s[31:0];
          sat_r   <= sat_r | v_s[32];
          state_r <= S_OUT;
        end
        S_A1: state_r <= S_A2;
        S_A2: begin
          acc_r   <= rnd_v;
          state_r <= S_A3;
        end
        S_A3: begin
          sat_r   <= sat_r | tq_s[32];
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_x_r     <= res_x_r;
            out_y_r     <= res_y_r;
            out_w_r     <= res_w_r;
            out_sat_r   <= sat_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_x         = out_x_r;
  assign out_y         = out_y_r;
  assign out_w         = out_w_r;
  assign out_saturated = out_sat_r;

endmodule
`default_nettype wire
